>>> rtl/mrw_pkg.sv
// shared types and constants of the miller-rabin witness round
package mrw_pkg;

    localparam int WORD_BITS = 63;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int EXP_W     = 6;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_MOD = 1'b1
    } mm_op_t;

    typedef struct packed {
        logic   start;
        mm_op_t op;
        word_t  opa;
        word_t  opb;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mm_rsp_t;

endpackage

>>> rtl/miller_rabin_witness_round_top.sv
// miller-rabin witness round: sequencer over a shared modular product unit
//
// usage: drive modulus_n, odd_part, two_power and witness_base and raise start
// while busy is low; the transaction is taken at that clock edge and busy stays
// high until the verdict is out. the verdict appears on probably_prime for one
// cycle with done high; the receiver cannot stall, so it must take it then.
// probably_prime is 1 when the base does not witness compositeness, 0 when the
// base witnesses compositeness or the modulus is below three.
// the base is first reduced modulo n, and every modular product then runs in
// the shared shift-and-add unit. the exponentiation runs one squaring per
// exponent bit and one multiply per set bit, then up to two_power - 1 further
// squarings follow. one transaction at a time.
// reset returns the sequencer to idle and drops any transaction in flight.
module miller_rabin_witness_round_top
    import mrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] modulus_n,
    input  logic [WORD_BITS-1:0] odd_part,
    input  logic [EXP_W-1:0]     two_power,
    input  logic [WORD_BITS-1:0] witness_base,
    output logic                 done,
    output logic                 probably_prime
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_REDUCE   = 9'b000000010,
        ST_POW_TEST = 9'b000000100,
        ST_POW_MUL  = 9'b000001000,
        ST_POW_SQR  = 9'b000010000,
        ST_CHECK    = 9'b000100000,
        ST_SQR_TEST = 9'b001000000,
        ST_SQR_WAIT = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    word_t              n_reg, n_next;
    word_t              e_reg, e_next;
    word_t              b_reg, b_next;
    word_t              x_reg, x_next;
    logic [EXP_W-1:0]   r_reg, r_next;
    logic [EXP_W-1:0]   i_reg, i_next;
    logic               verdict_reg, verdict_next;

    mm_req_t            mm_req;
    mm_rsp_t            mm_rsp;
    word_t              nm1;

    assign nm1 = n_reg - 1'b1;

    mrw_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (n_reg),
        .rsp     (mm_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        e_next       = e_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        r_next       = r_reg;
        i_next       = i_reg;
        verdict_next = verdict_reg;
        mm_req.start = 1'b0;
        mm_req.op    = OP_MUL;
        mm_req.opa   = x_reg;
        mm_req.opb   = b_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next = modulus_n;
                    e_next = odd_part;
                    r_next = two_power;
                    b_next = witness_base;
                    if (modulus_n < WORD_BITS'(3))
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                // wait for the reduction of the base issued on entry
                if (mm_rsp.done)
                begin
                    b_next     = mm_rsp.result;
                    x_next     = WORD_BITS'(1);
                    state_next = ST_POW_TEST;
                end
            end
            ST_POW_TEST:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else if (e_reg[0])
                begin
                    mm_req.start = 1'b1;
                    mm_req.opa   = x_reg;
                    mm_req.opb   = b_reg;
                    state_next   = ST_POW_MUL;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.opa   = b_reg;
                    mm_req.opb   = b_reg;
                    state_next   = ST_POW_SQR;
                end
            end
            ST_POW_MUL:
            begin
                if (mm_rsp.done)
                begin
                    x_next       = mm_rsp.result;
                    mm_req.start = 1'b1;
                    mm_req.opa   = b_reg;
                    mm_req.opb   = b_reg;
                    state_next   = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                if (mm_rsp.done)
                begin
                    b_next     = mm_rsp.result;
                    e_next     = e_reg >> 1;
                    state_next = ST_POW_TEST;
                end
            end
            ST_CHECK:
            begin
                if ((x_reg == WORD_BITS'(1)) || (x_reg == nm1))
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    i_next     = EXP_W'(1);
                    state_next = ST_SQR_TEST;
                end
            end
            ST_SQR_TEST:
            begin
                if (i_reg < r_reg)
                begin
                    mm_req.start = 1'b1;
                    mm_req.opa   = x_reg;
                    mm_req.opb   = x_reg;
                    state_next   = ST_SQR_WAIT;
                end
                else
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_SQR_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    x_next = mm_rsp.result;
                    if (mm_rsp.result == nm1)
                    begin
                        verdict_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SQR_TEST;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // reduction of the base is issued on the way into the reduce state
        if ((state_reg == ST_IDLE) && (state_next == ST_REDUCE))
        begin
            mm_req.start = 1'b1;
            mm_req.op    = OP_MOD;
            mm_req.opa   = '0;
            mm_req.opb   = witness_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
            i_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            i_reg       <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        e_reg <= e_next;
        b_reg <= b_next;
        x_reg <= x_next;
        r_reg <= r_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign probably_prime = verdict_reg;

endmodule

>>> rtl/mrw_modstep.sv
// one shift-and-add step with conditional subtraction of the modulus
module mrw_modstep
    import mrw_pkg::*;
(
    input  word_t acc,
    input  word_t addend,
    input  logic  add_en,
    input  logic  shift_in,
    input  word_t modulus,
    output word_t acc_out,
    output word_t addend_out
);

    logic [WORD_BITS:0] mod_ext;
    logic [WORD_BITS:0] sum;
    logic [WORD_BITS:0] sum_red;
    logic [WORD_BITS:0] shifted;
    logic [WORD_BITS:0] shifted_red;

    always_comb
    begin
        mod_ext     = {1'b0, modulus};
        sum         = {1'b0, acc} + {1'b0, addend};
        sum_red     = (sum >= mod_ext) ? (sum - mod_ext) : sum;
        shifted     = {addend, shift_in};
        shifted_red = (shifted >= mod_ext) ? (shifted - mod_ext) : shifted;
        acc_out     = add_en ? sum_red[WORD_BITS-1:0] : acc;
        addend_out  = shifted_red[WORD_BITS-1:0];
    end

endmodule

>>> rtl/mrw_mulmod.sv
// iterative modular product and modular reduction around one step unit
module mrw_mulmod
    import mrw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    input  word_t   modulus,
    output mm_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    mm_op_t             op_reg, op_next;
    word_t              acc_reg, acc_next;
    word_t              addend_reg, addend_next;
    word_t              y_reg, y_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    word_t              step_acc;
    word_t              step_addend;
    logic               add_en;
    logic               shift_in;
    logic               finished;

    // multiply consumes the multiplier lsb first, reduction feeds the dividend msb first
    assign add_en   = (op_reg == OP_MUL) && y_reg[0];
    assign shift_in = (op_reg == OP_MOD) && y_reg[WORD_BITS-1];
    assign finished = (op_reg == OP_MUL) ? (y_reg == '0)
                                         : (cnt_reg == CNT_W'(WORD_BITS));

    mrw_modstep u_step (
        .acc        (acc_reg),
        .addend     (addend_reg),
        .add_en     (add_en),
        .shift_in   (shift_in),
        .modulus    (modulus),
        .acc_out    (step_acc),
        .addend_out (step_addend)
    );

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        y_next      = y_reg;
        cnt_next    = cnt_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            op_next     = req.op;
            acc_next    = '0;
            addend_next = (req.op == OP_MUL) ? req.opa : '0;
            y_next      = req.opb;
            cnt_next    = '0;
        end
        else if (busy_reg)
        begin
            if (finished)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next    = step_acc;
                addend_next = step_addend;
                y_next      = (op_reg == OP_MUL) ? (y_reg >> 1) : (y_reg << 1);
                cnt_next    = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        y_reg      <= y_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_MUL) ? acc_reg : addend_reg;

endmodule
